FILE: hw/rtl/ifhg_pkg.sv
// Shared types and helpers for the IPv4 fragment header generator.
// Used by ifhg_ctrl, ifhg_dp and the top level; depends on nothing.
`default_nettype none

package ifhg_pkg;

   // Configuration and header constants
   localparam logic [13:0] MTU_RESET  = 14'd1500;
   localparam logic [13:0] MTU_MIN    = 14'd1052;
   localparam logic [13:0] MTU_MAX    = 14'd9000;
   localparam logic [13:0] HDR_BYTES  = 14'd20;
   localparam logic [15:0] VER_IHL_TOS = 16'h4500;
   localparam logic [7:0]  TTL_VALUE  = 8'd64;

   // Commands from the controller to the datapath
   typedef struct packed {
      logic load;   // capture the accepted item
      logic prep;   // work out slice size and base checksum
      logic emit;   // build one descriptor into the output register
   } ifhg_cmd_type;

   // Status from the datapath to the controller
   typedef struct packed {
      logic frag_last;  // the descriptor built now is the final one
   } ifhg_sts_type;

   // Fold a 20-bit sum of 16-bit words into a 16-bit ones'-complement sum
   function automatic logic [15:0] ones_fold(input logic [19:0] v);
      logic [16:0] s1;
      logic [16:0] s2;
      s1 = {1'b0, v[15:0]} + {13'd0, v[19:16]};
      s2 = {1'b0, s1[15:0]} + {16'd0, s1[16]};
      return s2[15:0];
   endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/ifhg_ctrl.sv
// Controller state machine for the IPv4 fragment header generator.
// Depends on ifhg_pkg; drives the datapath ifhg_dp by command signals.
`default_nettype none

module ifhg_ctrl
   import ifhg_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   output logic              req_ready,
   output logic              rsp_valid,
   input  wire logic         rsp_ready,
   output ifhg_cmd_type      cmd,
   input  wire ifhg_sts_type sts
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_PREP,
      ST_RUN
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      slot_free;

   // Output register may be refilled when empty or being taken
   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   // Next state and commands
   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd          = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_PREP;
            end
         end
         ST_PREP: begin
            cmd.prep = 1'b1;
            state_in = ST_RUN;
         end
         ST_RUN: begin
            if (slot_free) begin
               cmd.emit     = 1'b1;
               rsp_valid_in = 1'b1;
               if (sts.frag_last) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // A descriptor is only built into a free output register
   a_emit_slot: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> slot_free)
      else $error("descriptor built over an untaken result");

   // The final descriptor ends the datagram
   a_last_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.emit && sts.frag_last |=> req_ready && rsp_valid)
      else $error("datagram did not end after its final descriptor");

   // An accepted item blocks further input until it is done
   a_busy: assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> !req_ready && !rsp_valid_in || !req_ready)
      else $error("input taken while an item is in progress");

endmodule

`default_nettype wire

FILE: hw/rtl/ifhg_dp.sv
// Datapath for the IPv4 fragment header generator: mtu register, item
// capture, slice stepping, checksum and output register. Uses ifhg_pkg.
`default_nettype none

module ifhg_dp
   import ifhg_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         csr_wr_en,
   input  wire logic [13:0]  csr_wr_data,
   input  wire logic [7:0]   req_protocol,
   input  wire logic [31:0]  req_dest_ip,
   input  wire logic [31:0]  req_src_ip,
   input  wire logic [15:0]  req_payload_length,
   input  wire ifhg_cmd_type cmd,
   output ifhg_sts_type      sts,
   output logic [13:0]       rsp_total_length,
   output logic              rsp_more_fragments,
   output logic [12:0]       rsp_fragment_offset,
   output logic [15:0]       rsp_identification,
   output logic [15:0]       rsp_header_checksum,
   output logic [15:0]       rsp_slice_start,
   output logic [13:0]       rsp_slice_length,
   output logic              rsp_last
);

   // Control-type registers
   logic [13:0] mtu_ff;
   logic [15:0] ident_ff;

   // Captured item and per-datagram values
   logic [7:0]  proto_ff;
   logic [31:0] dst_ff, src_ff;
   logic [15:0] len_ff, id_ff, start_ff, base_ff;
   logic [13:0] piece_ff;

   // Output register; identification held here so a new item cannot disturb it
   logic [13:0] total_ff, slen_ff;
   logic [12:0] off_ff;
   logic [15:0] csum_ff, sstart_ff, idout_ff;
   logic        mf_ff;

   // Prep: saturated mtu, slice size and base sum
   logic [13:0] mtu_sat, piece_in;
   logic [19:0] base_sum;

   always_comb begin
      mtu_sat = mtu_ff;
      if (mtu_ff < MTU_MIN) begin
         mtu_sat = MTU_MIN;
      end else if (mtu_ff > MTU_MAX) begin
         mtu_sat = MTU_MAX;
      end
      piece_in = (mtu_sat - HDR_BYTES) & ~14'd7;
      base_sum = {4'd0, VER_IHL_TOS} + {4'd0, id_ff} + {4'd0, TTL_VALUE, proto_ff}
               + {4'd0, src_ff[31:16]} + {4'd0, src_ff[15:0]}
               + {4'd0, dst_ff[31:16]} + {4'd0, dst_ff[15:0]};
   end

   // One fragment: slice, flags and checksum
   logic [15:0] rest;
   logic        is_last;
   logic [13:0] slen, total;
   logic [13:0] flags_off;
   logic [19:0] frag_sum;
   logic [16:0] start_next;

   always_comb begin
      rest       = len_ff - start_ff;
      is_last    = (rest <= {2'd0, piece_ff});
      slen       = is_last ? rest[13:0] : piece_ff;
      total      = HDR_BYTES + slen;
      flags_off  = {!is_last, start_ff[15:3]};
      frag_sum   = {4'd0, base_ff} + {6'd0, total} + {6'd0, flags_off};
      start_next = {1'b0, start_ff} + {3'd0, piece_ff};
   end

   assign sts.frag_last = is_last;

   // mtu and identification counter
   always_ff @(posedge clock) begin
      if (reset) begin
         mtu_ff   <= MTU_RESET;
         ident_ff <= '0;
      end else begin
         if (csr_wr_en) begin
            mtu_ff <= csr_wr_data;
         end
         if (cmd.load) begin
            ident_ff <= ident_ff + 16'd1;
         end
      end
   end

   // Item capture, stepping and output register
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         proto_ff <= req_protocol;
         dst_ff   <= req_dest_ip;
         src_ff   <= req_src_ip;
         len_ff   <= req_payload_length;
         id_ff    <= ident_ff;
         start_ff <= '0;
      end
      if (cmd.prep) begin
         piece_ff <= piece_in;
         base_ff  <= ones_fold(base_sum);
      end
      if (cmd.emit) begin
         start_ff  <= start_next[15:0];
         total_ff  <= total;
         mf_ff     <= !is_last;
         off_ff    <= start_ff[15:3];
         idout_ff  <= id_ff;
         csum_ff   <= ~ones_fold(frag_sum);
         sstart_ff <= start_ff;
         slen_ff   <= slen;
      end
   end

   assign rsp_total_length    = total_ff;
   assign rsp_more_fragments  = mf_ff;
   assign rsp_fragment_offset = off_ff;
   assign rsp_identification  = idout_ff;
   assign rsp_header_checksum = csum_ff;
   assign rsp_slice_start     = sstart_ff;
   assign rsp_slice_length    = slen_ff;
   assign rsp_last            = !mf_ff;

   // Every fragment but the final one carries a full slice
   a_full_slice: assert property (@(posedge clock) disable iff (reset)
      cmd.emit && !is_last |-> slen == piece_ff)
      else $error("non-final fragment shorter than the slice size");

   // Slice size stays a non-zero multiple of eight
   a_piece: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> piece_ff[2:0] == 3'd0 && piece_ff != 14'd0)
      else $error("slice size not a multiple of eight");

   // Slices are contiguous within a datagram
   a_contig: assert property (@(posedge clock) disable iff (reset)
      cmd.emit ##1 cmd.emit |-> start_ff == $past(start_ff) + {2'd0, piece_ff})
      else $error("slice start did not advance by one slice");

endmodule

`default_nettype wire

FILE: hw/rtl/ipv4_fragment_header_generator.sv
// Top level of the IPv4 fragment header generator.
// Instantiates ifhg_ctrl and ifhg_dp; uses ifhg_pkg.
//
// Takes one datagram request and returns one IPv4 header descriptor per
// fragment, slices of (mtu - 20) rounded down to 8 bytes, the mtu being
// saturated into 1052..9000. A datagram is handled in steps: accept the
// request, work out the slice size and the fixed part of the checksum,
// then build one descriptor per cycle while the output register is free,
// from the single slice stepper and checksum adder; at most 64 fragments
// at the smallest mtu. The next request is accepted as soon as the final
// descriptor sits in the output register. No clearing pass after reset.
`default_nettype none

module ipv4_fragment_header_generator
   import ifhg_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_wr_en,
   input  wire logic [13:0] csr_wr_data,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [7:0]  req_protocol,
   input  wire logic [31:0] req_dest_ip,
   input  wire logic [31:0] req_src_ip,
   input  wire logic [15:0] req_payload_length,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [13:0]      rsp_total_length,
   output logic             rsp_more_fragments,
   output logic [12:0]      rsp_fragment_offset,
   output logic [15:0]      rsp_identification,
   output logic [15:0]      rsp_header_checksum,
   output logic [15:0]      rsp_slice_start,
   output logic [13:0]      rsp_slice_length,
   output logic             rsp_last
);

   ifhg_cmd_type cmd;
   ifhg_sts_type sts;

   ifhg_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd),
      .sts       (sts)
   );

   ifhg_dp u_dp (
      .clock               (clock),
      .reset               (reset),
      .csr_wr_en           (csr_wr_en),
      .csr_wr_data         (csr_wr_data),
      .req_protocol        (req_protocol),
      .req_dest_ip         (req_dest_ip),
      .req_src_ip          (req_src_ip),
      .req_payload_length  (req_payload_length),
      .cmd                 (cmd),
      .sts                 (sts),
      .rsp_total_length    (rsp_total_length),
      .rsp_more_fragments  (rsp_more_fragments),
      .rsp_fragment_offset (rsp_fragment_offset),
      .rsp_identification  (rsp_identification),
      .rsp_header_checksum (rsp_header_checksum),
      .rsp_slice_start     (rsp_slice_start),
      .rsp_slice_length    (rsp_slice_length),
      .rsp_last            (rsp_last)
   );

endmodule

`default_nettype wire

FILE: sim/ifhg_descr_check.sv
// Checker for the IPv4 fragment header generator: watches the csr, request
// and response ports, predicts every fragment descriptor and compares.
// Depends on ifhg_pkg for the mtu limits and header constants.

module ifhg_descr_check
   import ifhg_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_wr_en,
   input  wire logic [13:0] csr_wr_data,
   input  wire logic        req_valid,
   input  wire logic        req_ready,
   input  wire logic [7:0]  req_protocol,
   input  wire logic [31:0] req_dest_ip,
   input  wire logic [31:0] req_src_ip,
   input  wire logic [15:0] req_payload_length,
   input  wire logic        rsp_valid,
   input  wire logic        rsp_ready,
   input  wire logic [13:0] rsp_total_length,
   input  wire logic        rsp_more_fragments,
   input  wire logic [12:0] rsp_fragment_offset,
   input  wire logic [15:0] rsp_identification,
   input  wire logic [15:0] rsp_header_checksum,
   input  wire logic [15:0] rsp_slice_start,
   input  wire logic [13:0] rsp_slice_length,
   input  wire logic        rsp_last,
   output int               mismatch_count,
   output int               descr_pending,
   output int               descr_checked,
   output int               datagram_count
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [13:0] total_length;
      logic        more_fragments;
      logic [12:0] fragment_offset;
      logic [15:0] identification;
      logic [15:0] header_checksum;
      logic [15:0] slice_start;
      logic [13:0] slice_length;
      logic        last;
   } frag_descr_type;

   // Shadow copy of the block's register and identification counter
   logic [13:0]    mtu_shadow;
   logic [15:0]    next_ident;
   frag_descr_type expected_descr_q[$];
   int             bad_count;
   int             good_count;
   int             dgram_count;

   assign mismatch_count = bad_count;
   assign descr_checked  = good_count;
   assign datagram_count = dgram_count;

   // Ones'-complement header checksum, checksum word taken as zero
   function automatic logic [15:0] header_checksum_of(input logic [13:0] total,
                                                       input logic [15:0] ident,
                                                       input logic [15:0] flags_off,
                                                       input logic [7:0]  proto,
                                                       input logic [31:0] src,
                                                       input logic [31:0] dst);
      logic [31:0] acc;
      acc = 32'(VER_IHL_TOS) + 32'(total) + 32'(ident) + 32'(flags_off)
          + 32'({TTL_VALUE, proto}) + 32'(src[31:16]) + 32'(src[15:0])
          + 32'(dst[31:16]) + 32'(dst[15:0]);
      while (acc[31:16] != 16'd0)
         acc = {16'd0, acc[15:0]} + {16'd0, acc[31:16]};
      return ~acc[15:0];
   endfunction

   // Split one datagram into fragments and queue their descriptors
   function automatic void predict_fragments(input logic [7:0]  proto,
                                             input logic [31:0] dst,
                                             input logic [31:0] src,
                                             input logic [15:0] len,
                                             input logic [15:0] ident);
      int unsigned    m;
      int unsigned    piece;
      int unsigned    nfrag;
      int unsigned    start;
      int unsigned    slen;
      frag_descr_type d;
      m = mtu_shadow;
      if (m < MTU_MIN) m = MTU_MIN;
      if (m > MTU_MAX) m = MTU_MAX;
      piece = (m - HDR_BYTES) & ~32'd7;
      nfrag = (len + piece - 1) / piece;
      // an empty payload still gets one header-only fragment
      if (nfrag == 0) nfrag = 1;
      for (int unsigned i = 0; i < nfrag; i++) begin
         start = i * piece;
         slen = (len - start < piece) ? len - start : piece;
         d.more_fragments  = (i + 1 < nfrag);
         d.last            = !d.more_fragments;
         d.fragment_offset = 13'(start >> 3);
         d.slice_start     = 16'(start);
         d.slice_length    = 14'(slen);
         d.total_length    = 14'(slen + HDR_BYTES);
         d.identification  = ident;
         d.header_checksum = header_checksum_of(d.total_length, ident,
                                                {2'b00, d.more_fragments, d.fragment_offset},
                                                proto, src, dst);
         expected_descr_q.push_back(d);
      end
   endfunction

   function automatic string descr_text(input frag_descr_type d);
      return $sformatf("len=%0d mf=%0b off=%0d id=%04h csum=%04h start=%0d slice=%0d last=%0b",
                       d.total_length, d.more_fragments, d.fragment_offset, d.identification,
                       d.header_checksum, d.slice_start, d.slice_length, d.last);
   endfunction

   // Sample both channels at each edge, predict on request, compare on response
   always @(posedge clock) begin : watch
      frag_descr_type want;
      frag_descr_type got;
      if (reset) begin
         mtu_shadow = MTU_RESET;
         next_ident = '0;
         expected_descr_q.delete();
      end else begin
         if (csr_wr_en) mtu_shadow = csr_wr_data;
         if (req_valid && req_ready) begin
            predict_fragments(req_protocol, req_dest_ip, req_src_ip, req_payload_length,
                              next_ident);
            next_ident = next_ident + 16'd1;
            dgram_count++;
         end
         if (rsp_valid && rsp_ready) begin
            got = '{total_length:    rsp_total_length,
                    more_fragments:  rsp_more_fragments,
                    fragment_offset: rsp_fragment_offset,
                    identification:  rsp_identification,
                    header_checksum: rsp_header_checksum,
                    slice_start:     rsp_slice_start,
                    slice_length:    rsp_slice_length,
                    last:            rsp_last};
            if (expected_descr_q.size() == 0) begin
               if (bad_count < 10)
                  $display("%0t: unexpected descriptor %s", $realtime, descr_text(got));
               bad_count++;
            end else begin
               want = expected_descr_q.pop_front();
               if (got !== want) begin
                  if (bad_count < 10) begin
                     $display("%0t: descriptor mismatch", $realtime);
                     $display("   expected %s", descr_text(want));
                     $display("   actual   %s", descr_text(got));
                  end
                  bad_count++;
               end else begin
                  good_count++;
               end
            end
         end
      end
      descr_pending <= expected_descr_q.size();
   end

   initial begin
      bad_count   = 0;
      good_count  = 0;
      dgram_count = 0;
   end

endmodule

FILE: sim/tb_ipv4_fragment_header_generator.sv
// Testbench top for the IPv4 fragment header generator: clock, reset,
// mtu writes, request and response pacing, and the verdict.
// Depends on ifhg_pkg, ipv4_fragment_header_generator and ifhg_descr_check.

module tb_ipv4_fragment_header_generator
   import ifhg_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int RANDOM_ITEMS     = 320;
   localparam int MTU_PHASES       = 8;
   localparam int CYCLE_LIMIT      = 2_000_000;
   localparam int DRAIN_CYCLES     = 8;
   localparam int LONG_HOLD_CYCLES = 600;

   typedef enum logic [1:0] {READY_ALWAYS, READY_RANDOM, READY_SPARSE, READY_PATTERN}
      ready_mode_type;
   typedef enum logic [2:0] {LEN_TINY, LEN_EXACT, LEN_NEAR_EXACT, LEN_ANY, LEN_TOP}
      len_kind_type;

   logic        clock;
   logic        reset;
   logic        csr_wr_en;
   logic [13:0] csr_wr_data;
   logic        req_valid;
   logic        req_ready;
   logic [7:0]  req_protocol;
   logic [31:0] req_dest_ip;
   logic [31:0] req_src_ip;
   logic [15:0] req_payload_length;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [13:0] rsp_total_length;
   logic        rsp_more_fragments;
   logic [12:0] rsp_fragment_offset;
   logic [15:0] rsp_identification;
   logic [15:0] rsp_header_checksum;
   logic [15:0] rsp_slice_start;
   logic [13:0] rsp_slice_length;
   logic        rsp_last;

   int          mismatch_count;
   int          descr_pending;
   int          descr_checked;
   int          datagram_count;

   logic        long_hold_req;
   logic        long_hold_done;
   int          burst_left;
   int unsigned cur_piece;

   ipv4_fragment_header_generator dut (
      .clock               (clock),
      .reset               (reset),
      .csr_wr_en           (csr_wr_en),
      .csr_wr_data         (csr_wr_data),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_protocol        (req_protocol),
      .req_dest_ip         (req_dest_ip),
      .req_src_ip          (req_src_ip),
      .req_payload_length  (req_payload_length),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_total_length    (rsp_total_length),
      .rsp_more_fragments  (rsp_more_fragments),
      .rsp_fragment_offset (rsp_fragment_offset),
      .rsp_identification  (rsp_identification),
      .rsp_header_checksum (rsp_header_checksum),
      .rsp_slice_start     (rsp_slice_start),
      .rsp_slice_length    (rsp_slice_length),
      .rsp_last            (rsp_last)
   );

   ifhg_descr_check u_descr_check (
      .clock               (clock),
      .reset               (reset),
      .csr_wr_en           (csr_wr_en),
      .csr_wr_data         (csr_wr_data),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_protocol        (req_protocol),
      .req_dest_ip         (req_dest_ip),
      .req_src_ip          (req_src_ip),
      .req_payload_length  (req_payload_length),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_total_length    (rsp_total_length),
      .rsp_more_fragments  (rsp_more_fragments),
      .rsp_fragment_offset (rsp_fragment_offset),
      .rsp_identification  (rsp_identification),
      .rsp_header_checksum (rsp_header_checksum),
      .rsp_slice_start     (rsp_slice_start),
      .rsp_slice_length    (rsp_slice_length),
      .rsp_last            (rsp_last),
      .mismatch_count      (mismatch_count),
      .descr_pending       (descr_pending),
      .descr_checked       (descr_checked),
      .datagram_count      (datagram_count)
   );

   // 12 ns clock
   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Cycle limit
   initial begin : watchdog
      int cycles;
      cycles = 0;
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("Timeout after %0d cycles, %0d descriptors still due", cycles, descr_pending);
      $display("CHECK FAILED");
      $finish;
   end

   // Response side: random stall modes, each held for a random stretch; one long hold on request
   initial begin : receiver
      ready_mode_type mode;
      int             stretch;
      int             hold_count;
      logic [15:0]    pat;
      rsp_ready      <= 1'b0;
      long_hold_done <= 1'b0;
      mode       = READY_ALWAYS;
      stretch    = 0;
      hold_count = 0;
      pat        = 16'hffff;
      forever begin
         @(posedge clock);
         if (long_hold_req && !long_hold_done) begin
            rsp_ready <= 1'b0;
            hold_count++;
            if (hold_count == LONG_HOLD_CYCLES) long_hold_done <= 1'b1;
         end else begin
            if (stretch == 0) begin
               mode    = ready_mode_type'($urandom_range(0, 3));
               stretch = $urandom_range(20, 200);
               pat     = 16'($urandom) | 16'h0001;
            end
            stretch--;
            case (mode)
               READY_ALWAYS: rsp_ready <= 1'b1;
               READY_RANDOM: rsp_ready <= 1'($urandom_range(0, 1));
               READY_SPARSE: rsp_ready <= ($urandom_range(0, 3) == 0);
               default: begin
                  rsp_ready <= pat[0];
                  pat = {pat[0], pat[15:1]};
               end
            endcase
         end
      end
   end

   // Offer one datagram, wait for acceptance, then maybe end the burst with a gap
   task automatic offer_datagram(input logic [7:0]  proto,
                                 input logic [31:0] dst,
                                 input logic [31:0] src,
                                 input logic [15:0] len);
      req_valid          <= 1'b1;
      req_protocol       <= proto;
      req_dest_ip        <= dst;
      req_src_ip         <= src;
      req_payload_length <= len;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      burst_left--;
      if (burst_left <= 0) begin
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                                  : $urandom_range(1, 8);
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 20)) @(posedge clock);
      end
   endtask

   // Wait until every predicted descriptor has come out, plus a short tail
   task automatic wait_idle();
      if (req_valid) req_valid <= 1'b0;
      @(posedge clock);
      while (descr_pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Write the mtu register and note the slice size it gives, for shaping lengths
   task automatic write_mtu(input logic [13:0] value);
      int unsigned m;
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      m = (value < MTU_MIN) ? MTU_MIN : (value > MTU_MAX) ? MTU_MAX : value;
      cur_piece = (m - HDR_BYTES) & ~32'd7;
   endtask

   // Stimulus
   initial begin : stimulus
      logic [13:0]  mtu_plan [MTU_PHASES];
      len_kind_type kind;
      int unsigned  k;
      int unsigned  len_v;
      reset              <= 1'b1;
      csr_wr_en          <= 1'b0;
      csr_wr_data        <= '0;
      req_valid          <= 1'b0;
      req_protocol       <= '0;
      req_dest_ip        <= '0;
      req_src_ip         <= '0;
      req_payload_length <= '0;
      long_hold_req      <= 1'b0;
      burst_left = 4;
      cur_piece  = 1480;
      mtu_plan = '{14'd1052, 14'd9000, 14'd0, 14'd16383, 14'd1051, 14'd9001,
                   14'd1052, 14'd0};
      mtu_plan[6] = 14'($urandom_range(MTU_MIN, MTU_MAX));
      mtu_plan[7] = 14'($urandom_range(0, 16383));
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed items at the reset mtu (1480-byte slices)
      offer_datagram(8'd0,   32'h0000_0000, 32'h0000_0000, 16'd0);     // empty payload
      offer_datagram(8'd255, 32'hffff_ffff, 32'hffff_ffff, 16'd1);
      offer_datagram(8'd17,  32'hc0a8_0001, 32'h0a00_0001, 16'd1480);  // exactly one slice
      offer_datagram(8'd6,   32'haaaa_aaaa, 32'h5555_5555, 16'd1481);
      offer_datagram(8'd1,   32'h5555_5555, 32'haaaa_aaaa, 16'd2960);  // exact multiple
      offer_datagram(8'd132, 32'h8000_0001, 32'h0000_ffff, 16'd65515); // largest legal payload
      offer_datagram(8'd50,  32'hffff_0000, 32'h7fff_fffe, 16'd65535); // beyond legal payload
      offer_datagram(8'd6,   32'h0102_0304, 32'hfedc_ba98, 16'd8);
      offer_datagram(8'd17,  32'h1234_5678, 32'h8765_4321, 16'd1479);

      // One phase per mtu setting: in range, both saturation ends and random
      for (int ph = 0; ph < MTU_PHASES; ph++) begin
         wait_idle();
         write_mtu(mtu_plan[ph]);
         if (ph == 0) begin
            // smallest mtu: the most fragments a datagram can have
            offer_datagram(8'd253, 32'hffff_ffff, 32'h0000_0000, 16'd65535);
            offer_datagram(8'd254, 32'h0000_0000, 32'hffff_ffff, 16'd65016);
            offer_datagram(8'd0,   32'h0a0a_0a0a, 32'h0b0b_0b0b, 16'd0);
         end
         if (ph == 2) long_hold_req <= 1'b1;
         for (int n = 0; n < RANDOM_ITEMS / MTU_PHASES; n++) begin
            kind = len_kind_type'($urandom_range(0, 4));
            k = $urandom_range(1, 65535 / cur_piece);
            case (kind)
               LEN_TINY:       len_v = $urandom_range(0, 64);
               LEN_EXACT:      len_v = k * cur_piece;
               LEN_NEAR_EXACT: len_v = k * cur_piece + $urandom_range(0, 16) - 8;
               LEN_ANY:        len_v = $urandom_range(0, 65535);
               default:        len_v = $urandom_range(65400, 65535);
            endcase
            if (len_v > 65535) len_v = 65535;
            offer_datagram(8'($urandom), $urandom, $urandom, 16'(len_v));
         end
      end

      wait_idle();
      $display("Covered %0d datagrams and %0d fragment descriptors over %0d mtu settings,",
               datagram_count, descr_checked, MTU_PHASES + 1);
      $display("including both saturation ends and one %0d-cycle output stall; %0d mismatches",
               LONG_HOLD_CYCLES, mismatch_count);
      if (mismatch_count == 0 && descr_pending == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule

FILE: filelist.f
hw/rtl/ifhg_pkg.sv
hw/rtl/ifhg_ctrl.sv
hw/rtl/ifhg_dp.sv
hw/rtl/ipv4_fragment_header_generator.sv
sim/ifhg_descr_check.sv
sim/tb_ipv4_fragment_header_generator.sv
